[sv/mocg_pkg.sv]
package mocg_pkg;

  localparam int NUM_OUTS   = 16;
  localparam int OUT_W      = $clog2(NUM_OUTS);
  localparam int CNT_W      = 17;
  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int TBL_DEPTH  = 1024;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);
  localparam int STEP_W     = $clog2(TBL_AW + 1);
  localparam logic [GAIN_W-1:0] GAIN_FULL = 16'd32767;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // one ring position: active mark and fade counter
  typedef struct packed {
    logic             mark;
    logic [CNT_W-1:0] count;
  } cell_state_t;

  // shared cell control
  typedef struct packed {
    logic             shift;
    logic             set_en;
    logic [OUT_W-1:0] set_idx;
    logic             clr_en;
    logic [OUT_W-1:0] clr_idx;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_DIV,
    S_ROM,
    S_OUT
  } state_t;

  typedef logic [GAIN_W-1:0] gain_rom_t [TBL_DEPTH];

  // quarter-sine entry from a truncated taylor series in q30
  function automatic logic [GAIN_W-1:0] gain_entry(input logic [63:0] k);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] g;
    a    = (k * HALF_PI_Q30) >> TBL_AW;
    a2   = (a * a) >> 30;
    term = a;
    sum  = a;
    term = ((term * a2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * a2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * a2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * a2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * a2) >> 30) / 64'd110;
    sum  = sum - term;
    g = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (g > 64'(GAIN_FULL)) g = 64'(GAIN_FULL);
    return g[GAIN_W-1:0];
  endfunction

  function automatic gain_rom_t build_gain_rom();
    gain_rom_t t;
    for (int k = 0; k < TBL_DEPTH; k++) t[k] = gain_entry(64'(k));
    return t;
  endfunction

endpackage

[sv/mocg_cell.sv]
module mocg_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [mocg_pkg::OUT_W-1:0]     pos,
  input  mocg_pkg::cell_ctrl_t           ctrl,
  input  mocg_pkg::cell_state_t          in_word,
  output mocg_pkg::cell_state_t          word
);
  import mocg_pkg::*;

  // hold one output's state, take the neighbor's on a shift, else set or clear the mark when addressed
  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (ctrl.shift) begin
      word <= in_word;
    end else begin
      if (ctrl.set_en && ctrl.set_idx == pos) word.mark <= 1'b1;
      if (ctrl.clr_en && ctrl.clr_idx == pos) word.mark <= 1'b0;
    end
  end

endmodule

[sv/mocg_div.sv]
module mocg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mocg_pkg::CNT_W-1:0]    num,
  input  logic [mocg_pkg::CNT_W-1:0]    den,
  output logic                          busy,
  output logic [mocg_pkg::TBL_AW-1:0]   quot
);
  import mocg_pkg::*;

  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic [CNT_W:0]    rem2;

  assign rem2 = {rem, 1'b0};
  assign busy = (steps != '0);

  // restoring division of num * depth by den, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(TBL_AW);
    end else if (busy) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      quot <= '0;
    end else if (busy) begin
      if (rem2 >= {1'b0, den}) begin
        rem  <= CNT_W'(rem2 - {1'b0, den});
        quot <= {quot[TBL_AW-2:0], 1'b1};
      end else begin
        rem  <= rem2[CNT_W-1:0];
        quot <= {quot[TBL_AW-2:0], 1'b0};
      end
    end
  end

endmodule

[sv/multi_output_crossfade_gate.sv]
// a sample word passes through the step, divide, rom and output states for each output in use
// a sample word is taken only in idle, so the next waits until all 16 ring positions are stepped
//   and the 10-step gain index divider has run once per output in use
// select words are taken in idle and give no result
// reset: synchronous, clears marks, counters and choice; configuration registers go to 1
module multi_output_crossfade_gate (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // channel[2:0], sample_value[26:3], select_value[33:27]
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_index[3:0], out_channel[6:4], out_sample[30:7]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mocg_pkg::*;

  localparam gain_rom_t GAIN_ROM = build_gain_rom();

  logic [4:0]        outputs_in_use;
  logic [CNT_W-1:0]  fade_length;
  logic [4:0]        chosen;
  state_t            state, state_next;
  logic [OUT_W-1:0]  j;
  logic [2:0]        chan;
  logic signed [SAMPLE_W-1:0] sample;
  logic              full;
  logic [GAIN_W-1:0] rom_q;
  logic signed [SAMPLE_W+GAIN_W:0] prod;
  logic signed [SAMPLE_W+GAIN_W:0] rounded;
  logic [4:0]        n_eff;
  logic [CNT_W-1:0]  len_eff;
  logic [6:0]        sel;
  logic              in_acc;
  logic              out_free;
  logic              active_j;
  logic [CNT_W-1:0]  stepped;
  cell_ctrl_t        ctrl;
  cell_state_t       ring [NUM_OUTS];
  cell_state_t       head_next;
  logic              div_start;
  logic              div_busy;
  logic [TBL_AW-1:0] quot;

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      outputs_in_use <= 5'd1;
      fade_length    <= 17'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) fade_length    <= pwdata[CNT_W-1:0];
      else          outputs_in_use <= pwdata[4:0];
    end
  end
  assign prdata = paddr[2] ? 32'(fade_length) : 32'(outputs_in_use);

  // effective settings
  assign n_eff = (outputs_in_use == '0) ? 5'd1 :
                 (outputs_in_use > 5'(NUM_OUTS)) ? 5'(NUM_OUTS) : outputs_in_use;
  assign len_eff = (fade_length == '0) ? 17'd1 : fade_length;

  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign active_j = ({1'b0, j} < n_eff);
  assign sel      = (s_tdata[33:27] > 7'(n_eff)) ? 7'(n_eff) : s_tdata[33:27];

  // head counter step
  always_comb begin
    stepped = ring[0].count;
    if (ring[0].mark) begin
      if (ring[0].count < len_eff) stepped = ring[0].count + 1'b1;
    end else if (ring[0].count != '0) begin
      stepped = ring[0].count - 1'b1;
    end
    head_next.mark  = ring[0].mark;
    head_next.count = active_j ? stepped : ring[0].count;
  end

  // ring of cells, head at position 0
  for (genvar g = 0; g < NUM_OUTS; g++) begin : g_cell
    cell_state_t nb;
    if (g == NUM_OUTS - 1) begin : g_tail
      assign nb = head_next;
    end else begin : g_mid
      assign nb = ring[g+1];
    end
    mocg_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .pos     (OUT_W'(g)),
      .ctrl    (ctrl),
      .in_word (nb),
      .word    (ring[g])
    );
  end

  mocg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (stepped),
    .den   (len_eff),
    .busy  (div_busy),
    .quot  (quot)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc && !s_tuser) state_next = S_STEP;
      S_STEP: begin
        if (active_j)                        state_next = S_DIV;
        else if (j == OUT_W'(NUM_OUTS - 1))  state_next = S_IDLE;
      end
      S_DIV:  if (!div_busy) state_next = S_ROM;
      S_ROM:  state_next = S_OUT;
      S_OUT: begin
        if (out_free) state_next = (j == OUT_W'(NUM_OUTS - 1)) ? S_IDLE : S_STEP;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready     = (state == S_IDLE);
    div_start    = (state == S_STEP) && active_j;
    ctrl.shift   = (state == S_STEP);
    ctrl.set_en  = (state == S_IDLE) && in_acc && s_tuser &&
                   (5'(sel) != chosen) && (sel != '0);
    ctrl.set_idx = OUT_W'(sel - 7'd1);
    ctrl.clr_en  = (state == S_IDLE) && in_acc && s_tuser &&
                   (5'(sel) != chosen) && (chosen != '0);
    ctrl.clr_idx = OUT_W'(chosen - 5'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      chosen <= '0;
      j      <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_acc && s_tuser && 5'(sel) != chosen) chosen <= 5'(sel);
      if (state == S_IDLE) j <= '0;
      else if ((state == S_STEP && !active_j) || (state == S_OUT && out_free)) j <= j + 1'b1;
    end
  end

  // sample word capture and gain path
  always_ff @(posedge clk) begin
    if (in_acc) begin
      chan   <= s_tdata[2:0];
      sample <= s_tdata[26:3];
    end
    if (state == S_STEP) begin
      full <= (stepped >= len_eff);
    end
    rom_q <= GAIN_ROM[quot];
    if (state == S_ROM) prod <= sample * $signed({1'b0, full ? GAIN_FULL : rom_q});
  end

  assign rounded = prod + (SAMPLE_W+GAIN_W+1)'(16384);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= {1'b0, rounded[SAMPLE_W+14:15], chan, j};
      m_tlast <= ({1'b0, j} == n_eff - 5'd1);
    end
  end

endmodule
